// ===== hw/rtl/gsre_pkg.sv =====
// ----------------------------------------------------------------------------
// gsre_pkg
// Shared widths, limits, codes and control structs of the stroke run estimator.
// ----------------------------------------------------------------------------
package gsre_pkg;

  localparam int     LINE_MAX   = 4096;
  localparam longint PIXELS_MAX = 64'd16777216;

  localparam int MAG_W    = 16;
  localparam int DIR_W    = 8;
  localparam int IN_W     = MAG_W + DIR_W;
  localparam int RUN_W    = $clog2(2 * LINE_MAX);
  localparam int SUM_W    = $clog2(2 * PIXELS_MAX);
  localparam int CNT_W    = $clog2(PIXELS_MAX);
  localparam int FRAC_W   = 8;
  localparam int DVD_W    = SUM_W + FRAC_W;
  localparam int STEP_W   = $clog2(DVD_W);
  localparam int EST_W    = 22;
  localparam int OUT_W    = EST_W + 2 * SUM_W + 2 * CNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(2 * LINE_MAX - 1);
  localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(2 * PIXELS_MAX - 1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(PIXELS_MAX - 1);
  localparam logic [EST_W-1:0] EST_CAP = {EST_W{1'b1}};

  localparam logic [DIR_W-1:0] HALF_TURN = DIR_W'(128);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_A   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_B   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd3;

  localparam logic [MAG_W-1:0] THRESHOLD_RST = '0;
  localparam logic [DIR_W-1:0] ANGLE_A_RST   = DIR_W'(0);
  localparam logic [DIR_W-1:0] ANGLE_B_RST   = DIR_W'(128);
  localparam logic [DIR_W-1:0] TOLERANCE_RST = DIR_W'(16);

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel;
    logic keep_qa;
    logic keep_qb;
    logic load_out;
  } gsre_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } gsre_sts_t;

endpackage

// ===== hw/rtl/gradient_stroke_run_estimator.sv =====
// ----------------------------------------------------------------------------
// gradient_stroke_run_estimator
// Measures stroke runs between opposite gradient edges along scan lines.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle. The last pixel of an image (tlast) closes
// the image: the block then stops taking pixels while a single restoring
// divider, one quotient bit per cycle over 33 bits, works out the mean A run
// and then the mean B run; the result beat is loaded after that, later if
// the previous result beat has not yet been taken. Register writes belong in
// idle time between images.
module gradient_stroke_run_estimator import gsre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // magnitude, direction
  input  logic                  s_tuser,   // line_first
  input  logic                  s_tlast,   // image_last
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // run_estimate, a_run_sum, a_run_count, b_run_sum, b_run_count
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  gsre_cmd_t cmd;
  gsre_sts_t sts;

  gsre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gsre_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hw/rtl/gsre_div.sv =====
// ----------------------------------------------------------------------------
// gsre_div
// Restoring divider, one quotient bit per cycle, shared by both mean terms.
// ----------------------------------------------------------------------------
module gsre_div import gsre_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic              busy;
  logic [STEP_W-1:0] count;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, quotient[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so its top bit drops out
      rem      <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

`ifndef NO_ASSERTIONS
  a_div_finish: assert property (@(posedge clk) disable iff (rst)
    busy && !start && count == LAST_STEP |=> done && !busy)
    else $error("divider did not finish after its last step");
`endif

endmodule

// ===== hw/rtl/gsre_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsre_ctrl
// Sequencer: pixel intake, the two divisions and the hand-off to the output.
// ----------------------------------------------------------------------------
module gsre_ctrl import gsre_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_tlast,
  output logic      s_tready,
  input  gsre_sts_t sts,
  output gsre_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_START_A = 6'b000010,
    ST_DIV_A   = 6'b000100,
    ST_START_B = 6'b001000,
    ST_DIV_B   = 6'b010000,
    ST_LOAD    = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (s_tvalid && s_tlast) state_next = ST_START_A;
      ST_START_A: state_next = ST_DIV_A;
      ST_DIV_A:   if (sts.div_done) state_next = ST_START_B;
      ST_START_B: state_next = ST_DIV_B;
      ST_DIV_B:   if (sts.div_done) state_next = ST_LOAD;
      ST_LOAD:    if (sts.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept    = s_tvalid && (state == ST_IDLE);
    cmd.div_start = (state == ST_START_A) || (state == ST_START_B);
    cmd.div_sel   = (state == ST_START_B);
    cmd.keep_qa   = (state == ST_DIV_A) && sts.div_done;
    cmd.keep_qb   = (state == ST_DIV_B) && sts.div_done;
    cmd.load_out  = (state == ST_LOAD) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == ST_DIV_A || state == ST_DIV_B))
    else $error("divider finished outside a division state");
`endif

endmodule

// ===== hw/rtl/gsre_datapath.sv =====
// ----------------------------------------------------------------------------
// gsre_datapath
// Pixel classifier, run tracker, saturating totals, mean terms and result beat.
// ----------------------------------------------------------------------------
module gsre_datapath import gsre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  gsre_cmd_t             cmd,
  output gsre_sts_t             sts,
  input  logic [IN_W-1:0]       s_tdata,
  input  logic                  s_tuser,
  input  logic                  s_tlast,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata
);

  typedef enum logic [1:0] {
    CL_WEAK = 2'd0,
    CL_A    = 2'd1,
    CL_B    = 2'd2
  } pixel_class_t;

  typedef enum logic [4:0] {
    SC_WAIT   = 5'b00001,
    SC_WAIT_A = 5'b00010,
    SC_WAIT_B = 5'b00100,
    SC_RUN_A  = 5'b01000,
    SC_RUN_B  = 5'b10000
  } scan_state_t;

  function automatic logic [DIR_W-1:0] circ_dist(input logic [DIR_W-1:0] x,
                                                 input logic [DIR_W-1:0] y);
    logic [DIR_W-1:0] diff;
    diff = x - y;
    return (diff > HALF_TURN) ? DIR_W'(~diff + 1'b1) : diff;
  endfunction

  logic [MAG_W-1:0] threshold;
  logic [DIR_W-1:0] angle_a, angle_b, tolerance;

  logic [MAG_W-1:0] mag;
  logic [DIR_W-1:0] dir;
  pixel_class_t     cls;

  scan_state_t      scan_state, scan_next;
  logic [RUN_W-1:0] run_length, run_next, run_inc;
  logic             rec_a, rec_b;
  logic [SUM_W-1:0] a_total, b_total, a_total_next, b_total_next;
  logic [CNT_W-1:0] a_runs, b_runs, a_runs_next, b_runs_next;
  logic [SUM_W:0]   a_add, b_add;

  logic [SUM_W-1:0] res_a_sum, res_b_sum;
  logic [CNT_W-1:0] res_a_cnt, res_b_cnt;
  logic [DVD_W-1:0] qa, qb, quotient;
  logic             div_done;
  logic [DVD_W-1:0] mean_a, mean_b;
  logic [DVD_W:0]   est_sum;
  logic [EST_W-1:0] estimate;

  assign mag = s_tdata[MAG_W-1:0];
  assign dir = s_tdata[MAG_W +: DIR_W];

  always_comb begin
    if (mag < threshold) begin
      cls = CL_WEAK;
    end else if (circ_dist(dir, angle_a) < tolerance) begin
      cls = CL_A;
    end else if (circ_dist(dir, angle_b) < tolerance) begin
      cls = CL_B;
    end else begin
      cls = CL_WEAK;
    end
  end

  assign run_inc = (run_length < RUN_CAP) ? run_length + 1'b1 : RUN_CAP;

  always_comb begin
    scan_next = scan_state;
    run_next  = run_length;
    rec_a     = 1'b0;
    rec_b     = 1'b0;
    if (s_tuser) begin
      // line start only picks the start state and clears the run length
      run_next = '0;
      case (cls)
        CL_A:    scan_next = SC_WAIT_A;
        CL_B:    scan_next = SC_WAIT_B;
        default: scan_next = SC_WAIT;
      endcase
    end else begin
      case (scan_state)
        SC_WAIT_A: begin
          if (cls == CL_WEAK) begin
            scan_next = SC_WAIT;
            run_next  = '0;
          end else if (cls == CL_B) begin
            scan_next = SC_RUN_B;
          end
        end
        SC_WAIT_B: begin
          if (cls == CL_WEAK) begin
            scan_next = SC_WAIT;
            run_next  = '0;
          end else if (cls == CL_A) begin
            scan_next = SC_RUN_A;
          end
        end
        SC_RUN_A: begin
          if (cls == CL_A) begin
            run_next = run_inc;
          end else begin
            rec_a     = 1'b1;
            scan_next = (cls == CL_WEAK) ? SC_WAIT : SC_RUN_B;
            run_next  = (cls == CL_WEAK) ? '0 : RUN_W'(1);
          end
        end
        SC_RUN_B: begin
          if (cls == CL_B) begin
            run_next = run_inc;
          end else begin
            rec_b     = 1'b1;
            scan_next = (cls == CL_WEAK) ? SC_WAIT : SC_RUN_A;
            run_next  = (cls == CL_WEAK) ? '0 : RUN_W'(1);
          end
        end
        default: begin
          if (cls == CL_A) begin
            scan_next = SC_RUN_A;
            run_next  = run_inc;
          end else if (cls == CL_B) begin
            scan_next = SC_RUN_B;
            run_next  = run_inc;
          end
        end
      endcase
    end
  end

  assign a_add = {1'b0, a_total} + (SUM_W+1)'(run_length);
  assign b_add = {1'b0, b_total} + (SUM_W+1)'(run_length);

  always_comb begin
    a_total_next = a_total;
    b_total_next = b_total;
    a_runs_next  = a_runs;
    b_runs_next  = b_runs;
    if (rec_a) begin
      a_total_next = (a_add > {1'b0, SUM_CAP}) ? SUM_CAP : a_add[SUM_W-1:0];
      if (a_runs < CNT_CAP) a_runs_next = a_runs + 1'b1;
    end
    if (rec_b) begin
      b_total_next = (b_add > {1'b0, SUM_CAP}) ? SUM_CAP : b_add[SUM_W-1:0];
      if (b_runs < CNT_CAP) b_runs_next = b_runs + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RST;
      angle_a    <= ANGLE_A_RST;
      angle_b    <= ANGLE_B_RST;
      tolerance  <= TOLERANCE_RST;
      scan_state <= SC_WAIT;
      run_length <= '0;
      a_total    <= '0;
      b_total    <= '0;
      a_runs     <= '0;
      b_runs     <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_THRESHOLD: threshold <= wr_data[MAG_W-1:0];
          REG_ANGLE_A:   angle_a   <= wr_data[DIR_W-1:0];
          REG_ANGLE_B:   angle_b   <= wr_data[DIR_W-1:0];
          REG_TOLERANCE: tolerance <= wr_data[DIR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (s_tlast) begin
          // image end: open run dropped, next image starts clean
          scan_state <= SC_WAIT;
          run_length <= '0;
          a_total    <= '0;
          b_total    <= '0;
          a_runs     <= '0;
          b_runs     <= '0;
        end else begin
          scan_state <= scan_next;
          run_length <= run_next;
          a_total    <= a_total_next;
          b_total    <= b_total_next;
          a_runs     <= a_runs_next;
          b_runs     <= b_runs_next;
        end
      end
    end
  end

  // totals of the finished image, held while the divisions run
  always_ff @(posedge clk) begin
    if (cmd.accept && s_tlast) begin
      res_a_sum <= a_total_next;
      res_b_sum <= b_total_next;
      res_a_cnt <= a_runs_next;
      res_b_cnt <= b_runs_next;
    end
    if (cmd.keep_qa) qa <= quotient;
    if (cmd.keep_qb) qb <= quotient;
  end

  gsre_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel ? {res_b_sum, FRAC_W'(0)} : {res_a_sum, FRAC_W'(0)}),
    .divisor  (cmd.div_sel ? res_b_cnt : res_a_cnt),
    .quotient (quotient),
    .done     (div_done)
  );

  // an empty class contributes nothing
  assign mean_a   = (res_a_cnt == '0) ? '0 : qa;
  assign mean_b   = (res_b_cnt == '0) ? '0 : qb;
  assign est_sum  = {1'b0, mean_a} + {1'b0, mean_b};
  assign estimate = (est_sum > (DVD_W+1)'(EST_CAP)) ? EST_CAP : est_sum[EST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {res_b_cnt, res_b_sum, res_a_cnt, res_a_sum, estimate};
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !m_tvalid || m_tready;

`ifndef NO_ASSERTIONS
  a_wait_no_run: assert property (@(posedge clk) disable iff (rst)
    scan_state == SC_WAIT |-> run_length == '0)
    else $error("run length held while waiting for an edge");

  a_image_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && s_tlast |=> a_total == '0 && b_total == '0 &&
                              a_runs == '0 && b_runs == '0 && scan_state == SC_WAIT)
    else $error("totals not cleared after the last pixel");
`endif

endmodule

// ===== tb/sv/gradient_stroke_run_estimator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_stroke_run_estimator_tb
// Self-checking bench: drives scan lines of gradient pixels under several
// register settings and back-pressure mixes, predicts the per-image run
// statistics and compares every result beat field by field.
// ----------------------------------------------------------------------------
module gradient_stroke_run_estimator_tb import gsre_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 80;

  typedef enum logic [4:0] {
    ST_WAIT   = 5'b00001,
    ST_WAIT_B = 5'b00010,
    ST_WAIT_A = 5'b00100,
    ST_RUN_B  = 5'b01000,
    ST_RUN_A  = 5'b10000
  } scan_state_t;

  typedef enum logic [1:0] {
    PIX_WEAK = 2'd0,
    PIX_A    = 2'd1,
    PIX_B    = 2'd2
  } pix_class_t;

  // lowest field last in the declaration so that it lands in the low bits
  typedef struct packed {
    logic [CNT_W-1:0] b_cnt;
    logic [SUM_W-1:0] b_sum;
    logic [CNT_W-1:0] a_cnt;
    logic [SUM_W-1:0] a_sum;
    logic [EST_W-1:0] est;
  } run_stats_t;

  class run_stats_tracker_t;
    logic [MAG_W-1:0] thr;
    logic [DIR_W-1:0] ang_a;
    logic [DIR_W-1:0] ang_b;
    logic [DIR_W-1:0] tol;
    scan_state_t      st;
    logic [RUN_W-1:0] run_len;
    logic [SUM_W-1:0] a_sum;
    logic [SUM_W-1:0] b_sum;
    logic [CNT_W-1:0] a_cnt;
    logic [CNT_W-1:0] b_cnt;
    run_stats_t       expected_stats_q[$];
    int               errors;
    int               pixels;
    int               images;
    int               runs_closed;
    int               reg_writes;

    function new();
      thr   = THRESHOLD_RST;
      ang_a = ANGLE_A_RST;
      ang_b = ANGLE_B_RST;
      tol   = TOLERANCE_RST;
      errors = 0;
      pixels = 0;
      images = 0;
      runs_closed = 0;
      reg_writes = 0;
      clear_image();
    endfunction

    function void clear_image();
      st      = ST_WAIT;
      run_len = '0;
      a_sum   = '0;
      b_sum   = '0;
      a_cnt   = '0;
      b_cnt   = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      reg_writes++;
      case (idx)
        REG_THRESHOLD: thr   = val[MAG_W-1:0];
        REG_ANGLE_A:   ang_a = val[DIR_W-1:0];
        REG_ANGLE_B:   ang_b = val[DIR_W-1:0];
        REG_TOLERANCE: tol   = val[DIR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [8:0] circ_dist(logic [DIR_W-1:0] x, logic [DIR_W-1:0] y);
      logic [DIR_W-1:0] d;
      d = x - y;
      return (d > HALF_TURN) ? 9'(9'd256 - d) : 9'(d);
    endfunction

    function pix_class_t classify(logic [MAG_W-1:0] mag, logic [DIR_W-1:0] dir);
      if (mag < thr) return PIX_WEAK;
      if (circ_dist(dir, ang_a) < tol) return PIX_A;
      if (circ_dist(dir, ang_b) < tol) return PIX_B;
      return PIX_WEAK;
    endfunction

    function logic [RUN_W-1:0] bump(logic [RUN_W-1:0] v);
      return (v < RUN_CAP) ? v + 1'b1 : RUN_CAP;
    endfunction

    function void close_run(bit is_a);
      logic [SUM_W:0] s;
      runs_closed++;
      if (is_a) begin
        s = a_sum + run_len;
        a_sum = (s > SUM_CAP) ? SUM_CAP : s[SUM_W-1:0];
        if (a_cnt < CNT_CAP) a_cnt++;
      end else begin
        s = b_sum + run_len;
        b_sum = (s > SUM_CAP) ? SUM_CAP : s[SUM_W-1:0];
        if (b_cnt < CNT_CAP) b_cnt++;
      end
    endfunction

    function void advance(pix_class_t c);
      case (st)
        ST_WAIT_A: begin
          if (c == PIX_WEAK) begin
            st = ST_WAIT;
            run_len = '0;
          end else if (c == PIX_B) begin
            st = ST_RUN_B;
          end
        end
        ST_WAIT_B: begin
          if (c == PIX_WEAK) begin
            st = ST_WAIT;
            run_len = '0;
          end else if (c == PIX_A) begin
            st = ST_RUN_A;
          end
        end
        ST_RUN_A: begin
          if (c == PIX_A) begin
            run_len = bump(run_len);
          end else if (c == PIX_WEAK) begin
            close_run(1'b1);
            st = ST_WAIT;
            run_len = '0;
          end else begin
            close_run(1'b1);
            st = ST_RUN_B;
            run_len = RUN_W'(1);
          end
        end
        ST_RUN_B: begin
          if (c == PIX_B) begin
            run_len = bump(run_len);
          end else if (c == PIX_WEAK) begin
            close_run(1'b0);
            st = ST_WAIT;
            run_len = '0;
          end else begin
            close_run(1'b0);
            st = ST_RUN_A;
            run_len = RUN_W'(1);
          end
        end
        default: begin
          if (c == PIX_A) begin
            st = ST_RUN_A;
            run_len = bump(run_len);
          end else if (c == PIX_B) begin
            st = ST_RUN_B;
            run_len = bump(run_len);
          end
        end
      endcase
    endfunction

    function void note_pixel(logic [MAG_W-1:0] mag, logic [DIR_W-1:0] dir, bit first,
                             bit last);
      pix_class_t       c;
      run_stats_t       want;
      logic [DVD_W-1:0] mean_a;
      logic [DVD_W-1:0] mean_b;
      logic [DVD_W:0]   est;
      pixels++;
      c = classify(mag, dir);
      if (first) begin
        run_len = '0;
        case (c)
          PIX_A:   st = ST_WAIT_A;
          PIX_B:   st = ST_WAIT_B;
          default: st = ST_WAIT;
        endcase
      end else begin
        advance(c);
      end
      if (last) begin
        mean_a = (a_cnt != 0) ? {a_sum, 8'h00} / a_cnt : '0;
        mean_b = (b_cnt != 0) ? {b_sum, 8'h00} / b_cnt : '0;
        est = mean_a + mean_b;
        want.est   = (est > EST_CAP) ? EST_CAP : est[EST_W-1:0];
        want.a_sum = a_sum;
        want.a_cnt = a_cnt;
        want.b_sum = b_sum;
        want.b_cnt = b_cnt;
        expected_stats_q = {expected_stats_q, want};
        clear_image();
      end
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_stats(logic [OUT_W-1:0] data);
      run_stats_t got;
      run_stats_t want;
      got = data;
      if (expected_stats_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, data);
        return;
      end
      want = expected_stats_q.pop_front();
      images++;
      cmp_field("run_estimate", 32'(want.est),   32'(got.est));
      cmp_field("a_run_sum",    32'(want.a_sum), 32'(got.a_sum));
      cmp_field("a_run_count",  32'(want.a_cnt), 32'(got.a_cnt));
      cmp_field("b_run_sum",    32'(want.b_sum), 32'(got.b_sum));
      cmp_field("b_run_count",  32'(want.b_cnt), 32'(got.b_cnt));
    endfunction

    function int pending();
      return expected_stats_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;   // magnitude, direction
  logic                  s_tuser;   // line_first
  logic                  s_tlast;   // image_last
  logic                  m_tvalid;
  logic                  m_tready;
  // run_estimate, a_run_sum, a_run_count, b_run_sum, b_run_count
  logic [OUT_W-1:0]      m_tdata;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  run_stats_tracker_t tracker;
  int               send_idle;
  int               recv_stall;
  int               quiet_cycles;
  logic [MAG_W-1:0] cur_thr;
  logic [DIR_W-1:0] cur_a;
  logic [DIR_W-1:0] cur_b;
  logic [DIR_W-1:0] cur_tol;

  gradient_stroke_run_estimator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) tracker.check_stats(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, tracker.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [MAG_W-1:0] mag, logic [DIR_W-1:0] dir, bit first,
                            bit last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {dir, mag};
    s_tuser  = first;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    tracker.note_pixel(mag, dir, first, last);
  endtask

  task automatic idle_input();
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // every outstanding result taken, then room for any pixel still in flight
  task automatic settle();
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] a,
                            logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] tol);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_ANGLE_A, a);
    write_reg(REG_ANGLE_B, b);
    write_reg(REG_TOLERANCE, tol);
    @(negedge clk);
    wr_en   = 1'b0;
    cur_thr = thr;
    cur_a   = a[DIR_W-1:0];
    cur_b   = b[DIR_W-1:0];
    cur_tol = tol[DIR_W-1:0];
  endtask

  // aims at a class under the current settings; the tracker decides the truth
  task automatic make_pixel(pix_class_t want, output logic [MAG_W-1:0] mag,
                            output logic [DIR_W-1:0] dir);
    int span;
    int off;
    mag  = MAG_W'($urandom_range(65535, cur_thr));
    span = (cur_tol > 0 && cur_tol <= HALF_TURN) ? int'(cur_tol) - 1 : 127;
    off  = int'($urandom_range(2 * span)) - span;
    case (want)
      PIX_A: dir = cur_a + DIR_W'(off);
      PIX_B: dir = cur_b + DIR_W'(off);
      default: begin
        if (cur_thr != 0 && $urandom_range(1) == 1) mag = MAG_W'($urandom_range(cur_thr - 1, 0));
        dir = DIR_W'($urandom);
      end
    endcase
    if ($urandom_range(99) < 8) begin
      mag = MAG_W'($urandom);
      dir = DIR_W'($urandom);
    end
  endtask

  task automatic send_image(int n_lines, int max_len, inout int items);
    int               len;
    pix_class_t       cls;
    logic [MAG_W-1:0] mag;
    logic [DIR_W-1:0] dir;
    bit               first;
    bit               last;
    cls = PIX_WEAK;
    for (int l = 0; l < n_lines; l++) begin
      len = $urandom_range(max_len, 1);
      for (int p = 0; p < len; p++) begin
        if ($urandom_range(99) < 35) cls = pix_class_t'($urandom_range(2));
        make_pixel(cls, mag, dir);
        first = (p == 0);
        // the odd broken line marker
        if ($urandom_range(99) < 3) first = ~first;
        last = (l == n_lines - 1) && (p == len - 1);
        send_pixel(mag, dir, first, last);
        items++;
      end
    end
    idle_input();
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] a,
                           logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] tol,
                           int idle_pct, int stall_pct, int n_items);
    int items;
    int n_img;
    items = 0;
    n_img = 0;
    settle();
    set_config(thr, a, b, tol);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    while (items < n_items) begin
      send_image($urandom_range(4, 1), 12, items);
      n_img++;
      // after the third image, hold the stream until every image so far has been reported
      if (n_img == 3) while (tracker.pending() > 0) @(posedge clk);
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    s_tlast    = 1'b0;
    m_tready   = 1'b1;
    wr_en      = 1'b0;
    wr_index   = '0;
    wr_data    = '0;
    send_idle  = 0;
    recv_stall = 0;
    quiet_cycles = 0;
    cur_thr    = THRESHOLD_RST;
    cur_a      = ANGLE_A_RST;
    cur_b      = ANGLE_B_RST;
    cur_tol    = TOLERANCE_RST;
    tracker    = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings; pixels before any line start run from the wait state
    send_pixel(16'hFFFF, 8'd0,   1'b0, 1'b0);
    send_pixel(16'h0000, 8'd15,  1'b0, 1'b0);   // just inside the tolerance
    send_pixel(16'h1234, 8'd128, 1'b0, 1'b0);
    send_pixel(16'hABCD, 8'd143, 1'b0, 1'b0);
    send_pixel(16'h5555, 8'd16,  1'b0, 1'b0);   // distance equal to tolerance
    send_pixel(16'h00FF, 8'd113, 1'b1, 1'b0);   // line start on a b edge
    send_pixel(16'hFF00, 8'd241, 1'b0, 1'b0);
    send_pixel(16'h8000, 8'd1,   1'b0, 1'b0);
    send_pixel(16'h7FFF, 8'd64,  1'b0, 1'b0);
    send_pixel(16'hAAAA, 8'd255, 1'b1, 1'b0);   // line start on an a edge
    send_pixel(16'h0001, 8'd129, 1'b0, 1'b0);
    send_pixel(16'hFFFE, 8'd130, 1'b0, 1'b0);
    send_pixel(16'h4000, 8'd2,   1'b0, 1'b0);
    send_pixel(16'h2000, 8'd200, 1'b1, 1'b0);   // open run dropped at line start
    send_pixel(16'h3C3C, 8'd250, 1'b0, 1'b0);
    send_pixel(16'hC3C3, 8'd5,   1'b0, 1'b1);   // open run dropped at image end
    idle_input();
    while (tracker.pending() > 0) @(posedge clk);

    // top threshold, half-turn tolerance, junk in the unused register bits
    settle();
    set_config(16'hFFFF, 16'hA5FF, 16'h5A7F, 16'd128);
    send_pixel(16'hFFFE, 8'd0,   1'b1, 1'b0);
    send_pixel(16'hFFFF, 8'd0,   1'b0, 1'b0);
    send_pixel(16'hFFFF, 8'd127, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 8'd128, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 8'd127, 1'b1, 1'b1);   // line start that ends the image
    idle_input();

    run_phase(16'd0,     16'd0,   16'd128, 16'd16,  0,  0,  180);
    run_phase(16'h8000,  16'd64,  16'd192, 16'd32,  85, 0,  180);
    run_phase(16'hFFFF,  16'd255, 16'd127, 16'd128, 0,  85, 180);
    run_phase(16'($urandom_range(4000)), 16'($urandom), 16'($urandom),
              16'($urandom_range(128, 1)), 19, 19, 180);
    run_phase(16'd0,     16'd10,  16'd10,  16'd20,  0,  0,  180);   // a wins over b
    run_phase(16'($urandom_range(300)), 16'd200, 16'd72, 16'd255, 85, 0, 180);
    run_phase(16'd0,     16'($urandom), 16'($urandom), 16'd0, 0, 85, 180);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom_range(128)), 19, 19, 180);

    settle();
    $display("covered %0d pixels in %0d images, %0d finished runs, %0d register writes",
             tracker.pixels, tracker.images, tracker.runs_closed, tracker.reg_writes);
    $display("settings swept threshold and tolerance extremes under mixed back-pressure");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
